>>> rtl/rmvs_pkg.sv
// ----------------------------------------------------------------------------
// rmvs_pkg: shared types and constants for the running statistics block
// Field widths, fixed-point layout, widths of the shared arithmetic unit and
// its step counter, scale factors, and the sequencer state and unit mode types.
// ----------------------------------------------------------------------------
package rmvs_pkg;

  localparam int NUM_STREAMS = 16;
  localparam int ID_W        = 4;
  localparam int SMP_W       = 24;
  localparam int FRAC_BITS   = 16;
  localparam int CNT_W       = 32;
  localparam int MEAN_W      = SMP_W + FRAC_BITS;
  localparam int M2_W        = 64;
  localparam int BND_W       = 44;

  // Shared unit datapath width: the widest dividend is M2 * 38416 * 2^FRAC_BITS.
  localparam int UNIT_W      = 96;
  localparam int STEP_W      = 7;

  // Scale factors: 3 sigma squared is 9, 1.96 squared is 38416 / 10000.
  localparam int                 SIG_K_W   = 4;
  localparam int                 MG_NUM_W  = 16;
  localparam int                 MG_DEN_W  = 14;
  localparam logic [MG_NUM_W-1:0] MG_NUM   = 16'd38416;
  localparam logic [MG_DEN_W-1:0] MG_DEN   = 14'd10000;

  // Dividend width of the sigma path: M2 * 9 * 2^FRAC_BITS.
  localparam int SIG_NUM_W   = M2_W + SIG_K_W + FRAC_BITS;

  localparam logic [CNT_W-1:0] SIGMA_MIN_N = 32'd2;
  localparam logic [CNT_W-1:0] IV_MIN_N    = 32'd30;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIFF,
    ST_DIV_MEAN,
    ST_MEAN_UPD,
    ST_DIFF2,
    ST_MUL_SQ,
    ST_M2_ADD,
    ST_STATS,
    ST_SIG_PREP,
    ST_SIG_DIV,
    ST_SIG_SQRT,
    ST_SIG_HI,
    ST_SIG_LO,
    ST_MG_PREP,
    ST_MG_MUL_A,
    ST_MG_MUL_N,
    ST_MG_MUL_K,
    ST_MG_DIV,
    ST_MG_SQRT,
    ST_MG_HI,
    ST_MG_LO,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    U_NONE,
    U_ADD,
    U_SUB,
    U_MUL,
    U_DIV,
    U_SQRT
  } unit_mode_e;

endpackage

>>> rtl/running_mean_variance_stats.sv
// ----------------------------------------------------------------------------
// running_mean_variance_stats: per-stream running mean, variance and bounds
// Each input word carries a stream number and an unsigned sample. The block
// keeps, per stream, a sample count, a running mean with 16 fractional bits,
// the sum of squared deviations (Welford update) and the minimum and maximum.
// For every input word one result word is returned with the updated values,
// mean +/- 3 sigma (valid from two samples) and the 95% confidence interval
// (valid above 30 samples).
// Both channels use valid/ready. The input is ready only while the sequencer
// is idle; one word is processed at a time. All arithmetic runs on a single
// shared 96-bit add/subtract unit that also performs bit-serial multiply,
// restoring divide and digit-by-digit square root steps, and the step counts
// of those phases set the timing. The next word can be accepted in the cycle
// after the result is registered. The result sits in an output register, so
// a stalled receiver only holds the block when the next result is ready to
// be written. Reset clears the per-stream seen flags; the other per-stream
// stores are written before read.
// ----------------------------------------------------------------------------
module running_mean_variance_stats (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rmvs_pkg::ID_W-1:0]         stream_id_i,
  input  logic [rmvs_pkg::SMP_W-1:0]        sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rmvs_pkg::ID_W-1:0]         stream_echo_o,
  output logic [rmvs_pkg::CNT_W-1:0]        sample_count_o,
  output logic [rmvs_pkg::MEAN_W-1:0]       mean_value_o,
  output logic [rmvs_pkg::SMP_W-1:0]        min_seen_o,
  output logic [rmvs_pkg::SMP_W-1:0]        max_seen_o,
  output logic                              sigma_ok_o,
  output logic signed [rmvs_pkg::BND_W-1:0] sigma_low_o,
  output logic signed [rmvs_pkg::BND_W-1:0] sigma_high_o,
  output logic                              interval_ok_o,
  output logic signed [rmvs_pkg::BND_W-1:0] interval_low_o,
  output logic signed [rmvs_pkg::BND_W-1:0] interval_high_o,
  output logic                              saturated_o
);
  import rmvs_pkg::*;

  // Sequencer and per-item working registers.
  state_e              state_q, state_d;
  logic [ID_W-1:0]     id_q;
  logic [SMP_W-1:0]    smp_q;
  logic [CNT_W-1:0]    n_q;
  logic [MEAN_W-1:0]   mean_q;
  logic [M2_W-1:0]     m2_q;
  logic [SMP_W-1:0]    min_q, max_q;
  logic                drop_q;
  logic                x_ge_q;
  logic [MEAN_W-1:0]   d_q;
  logic [STEP_W-1:0]   cnt_q;

  // Shared unit registers: accumulator or remainder, operand or root,
  // multiplier or dividend or radicand, and a holding register.
  logic [UNIT_W-1:0]   acc_q, opa_q, mq_q, hold_q;

  // Bound results of the current item.
  logic                sig_ok_q, iv_ok_q;
  logic [BND_W-1:0]    sig_lo_q, sig_hi_q, iv_lo_q, iv_hi_q;

  // Per-stream stores. Only the seen flags are reset.
  logic [NUM_STREAMS-1:0] seen_q;
  logic [CNT_W-1:0]    cnt_mem  [NUM_STREAMS];
  logic [MEAN_W-1:0]   mean_mem [NUM_STREAMS];
  logic [M2_W-1:0]     m2_mem   [NUM_STREAMS];
  logic [SMP_W-1:0]    min_mem  [NUM_STREAMS];
  logic [SMP_W-1:0]    max_mem  [NUM_STREAMS];

  // Output register.
  logic                out_valid_q;
  logic [ID_W-1:0]     o_id_q;
  logic [CNT_W-1:0]    o_n_q;
  logic [MEAN_W-1:0]   o_mean_q;
  logic [SMP_W-1:0]    o_min_q, o_max_q;
  logic                o_sig_ok_q, o_iv_ok_q, o_sat_q;
  logic [BND_W-1:0]    o_sig_lo_q, o_sig_hi_q, o_iv_lo_q, o_iv_hi_q;

  // Combinational signals.
  unit_mode_e          mode;
  logic [UNIT_W-1:0]   op_x, op_y;
  logic [UNIT_W-1:0]   alu_a, alu_b;
  logic                alu_sub;
  logic [UNIT_W:0]     sum;
  logic                no_borrow;
  logic [UNIT_W-1:0]   rem_div, rem_sqrt, trial, mul_acc_nx;
  logic                last_step;
  logic                out_load;
  logic [MEAN_W-1:0]   x_val;
  logic                x_ge;
  logic                id_oor;
  logic                cnt_full;
  logic [M2_W-1:0]     m2_nx;

  assign x_val     = {smp_q, {FRAC_BITS{1'b0}}};
  assign x_ge      = (x_val >= mean_q);
  assign id_oor    = ({1'b0, id_q} >= (ID_W+1)'(NUM_STREAMS));
  assign cnt_full  = (cnt_mem[id_q] == {CNT_W{1'b1}});
  assign last_step = (cnt_q == STEP_W'(1));
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == ST_IDLE);

  // Saturate a sum to the largest positive bound.
  function automatic logic [BND_W-1:0] sat_hi(input logic [UNIT_W:0] s);
    logic [BND_W-1:0] r;
    if (|s[UNIT_W-1:BND_W-1]) begin
      r = {1'b0, {(BND_W-1){1'b1}}};
    end else begin
      r = s[BND_W-1:0];
    end
    return r;
  endfunction

  // Difference mean - s: kept when there is no borrow or when the negative
  // result fits the bound, else clamped at the most negative bound.
  function automatic logic [BND_W-1:0] sat_lo(input logic [UNIT_W:0] s);
    logic [BND_W-1:0] r;
    if (s[UNIT_W] || (&s[UNIT_W-1:BND_W-1])) begin
      r = s[BND_W-1:0];
    end else begin
      r = {1'b1, {(BND_W-1){1'b0}}};
    end
    return r;
  endfunction

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP: begin
        if (id_oor) begin
          state_d = ST_DONE;
        end else if (!seen_q[id_q] || cnt_full) begin
          state_d = ST_STATS;
        end else begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF:     state_d = ST_DIV_MEAN;
      ST_DIV_MEAN: if (last_step) state_d = ST_MEAN_UPD;
      ST_MEAN_UPD: state_d = ST_DIFF2;
      ST_DIFF2:    state_d = ST_MUL_SQ;
      ST_MUL_SQ:   if (last_step) state_d = ST_M2_ADD;
      ST_M2_ADD:   state_d = ST_STATS;
      ST_STATS:    state_d = (n_q >= SIGMA_MIN_N) ? ST_SIG_PREP : ST_DONE;
      ST_SIG_PREP: state_d = ST_SIG_DIV;
      ST_SIG_DIV:  if (last_step) state_d = ST_SIG_SQRT;
      ST_SIG_SQRT: if (last_step) state_d = ST_SIG_HI;
      ST_SIG_HI:   state_d = ST_SIG_LO;
      ST_SIG_LO:   state_d = (n_q > IV_MIN_N) ? ST_MG_PREP : ST_DONE;
      ST_MG_PREP:  state_d = ST_MG_MUL_A;
      ST_MG_MUL_A: if (last_step) state_d = ST_MG_MUL_N;
      ST_MG_MUL_N: if (last_step) state_d = ST_MG_MUL_K;
      ST_MG_MUL_K: if (last_step) state_d = ST_MG_DIV;
      ST_MG_DIV:   if (last_step) state_d = ST_MG_SQRT;
      ST_MG_SQRT:  if (last_step) state_d = ST_MG_HI;
      ST_MG_HI:    state_d = ST_MG_LO;
      ST_MG_LO:    state_d = ST_DONE;
      ST_DONE:     if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Unit mode and plain add/subtract operands for each state.
  always_comb begin
    mode = U_NONE;
    op_x = '0;
    op_y = '0;
    case (state_q)
      ST_DIFF, ST_DIFF2: begin
        // In ST_DIFF2 the direction of the first difference still holds.
        mode = U_SUB;
        if ((state_q == ST_DIFF) ? x_ge : x_ge_q) begin
          op_x = UNIT_W'(x_val);
          op_y = UNIT_W'(mean_q);
        end else begin
          op_x = UNIT_W'(mean_q);
          op_y = UNIT_W'(x_val);
        end
      end
      ST_MEAN_UPD: begin
        mode = x_ge_q ? U_ADD : U_SUB;
        op_x = UNIT_W'(mean_q);
        op_y = UNIT_W'(mq_q[MEAN_W-1:0]);
      end
      ST_M2_ADD: begin
        mode = U_ADD;
        op_x = UNIT_W'(m2_q);
        op_y = UNIT_W'(acc_q[2*MEAN_W-1:FRAC_BITS]);
      end
      ST_SIG_PREP: begin
        // 9 * M2 as (M2 << 3) + M2.
        mode = U_ADD;
        op_x = UNIT_W'({m2_q, 3'b000});
        op_y = UNIT_W'(m2_q);
      end
      ST_SIG_HI, ST_MG_HI: begin
        mode = U_ADD;
        op_x = UNIT_W'(mean_q);
        op_y = opa_q;
      end
      ST_SIG_LO, ST_MG_LO: begin
        mode = U_SUB;
        op_x = UNIT_W'(mean_q);
        op_y = opa_q;
      end
      ST_MUL_SQ, ST_MG_MUL_A, ST_MG_MUL_N, ST_MG_MUL_K: mode = U_MUL;
      ST_DIV_MEAN, ST_SIG_DIV, ST_MG_DIV:               mode = U_DIV;
      ST_SIG_SQRT, ST_MG_SQRT:                          mode = U_SQRT;
      default:                                          mode = U_NONE;
    endcase
  end

  // Shared add/subtract unit and the operand selection of the step modes.
  always_comb begin
    rem_div  = {acc_q[UNIT_W-2:0], mq_q[UNIT_W-1]};
    rem_sqrt = {acc_q[UNIT_W-3:0], mq_q[UNIT_W-1 -: 2]};
    trial    = {opa_q[UNIT_W-3:0], 2'b01};
    alu_a    = op_x;
    alu_b    = op_y;
    alu_sub  = 1'b0;
    case (mode)
      U_MUL: begin
        alu_a = acc_q;
        alu_b = opa_q;
      end
      U_DIV: begin
        alu_a   = rem_div;
        alu_b   = opa_q;
        alu_sub = 1'b1;
      end
      U_SQRT: begin
        alu_a   = rem_sqrt;
        alu_b   = trial;
        alu_sub = 1'b1;
      end
      U_SUB:   alu_sub = 1'b1;
      default: alu_sub = 1'b0;
    endcase
    sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
        + {{UNIT_W{1'b0}}, alu_sub};
    no_borrow  = sum[UNIT_W];
    mul_acc_nx = mq_q[0] ? sum[UNIT_W-1:0] : acc_q;
    m2_nx      = (|sum[UNIT_W:M2_W]) ? {M2_W{1'b1}} : sum[M2_W-1:0];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      seen_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_LOOKUP && !id_oor) begin
        seen_q[id_q] <= 1'b1;
      end
    end
  end

  // Per-stream store writes: a first sample starts the entry, an update
  // writes the whole entry back once M2 is known.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOKUP && !id_oor && !seen_q[id_q]) begin
      cnt_mem[id_q]  <= CNT_W'(1);
      mean_mem[id_q] <= x_val;
      m2_mem[id_q]   <= '0;
      min_mem[id_q]  <= smp_q;
      max_mem[id_q]  <= smp_q;
    end else if (state_q == ST_M2_ADD) begin
      cnt_mem[id_q]  <= n_q;
      mean_mem[id_q] <= mean_q;
      m2_mem[id_q]   <= m2_nx;
      min_mem[id_q]  <= min_q;
      max_mem[id_q]  <= max_q;
    end
  end

  // Datapath. Step modes advance the shared unit; the state case then sets
  // up the next operation on the last step of each phase.
  always_ff @(posedge clk_i) begin
    case (mode)
      U_MUL: begin
        acc_q <= mul_acc_nx;
        opa_q <= {opa_q[UNIT_W-2:0], 1'b0};
        mq_q  <= {1'b0, mq_q[UNIT_W-1:1]};
        cnt_q <= cnt_q - STEP_W'(1);
      end
      U_DIV: begin
        acc_q <= no_borrow ? sum[UNIT_W-1:0] : rem_div;
        mq_q  <= {mq_q[UNIT_W-2:0], no_borrow};
        cnt_q <= cnt_q - STEP_W'(1);
      end
      U_SQRT: begin
        acc_q <= no_borrow ? sum[UNIT_W-1:0] : rem_sqrt;
        opa_q <= {opa_q[UNIT_W-2:0], no_borrow};
        mq_q  <= {mq_q[UNIT_W-3:0], 2'b00};
        cnt_q <= cnt_q - STEP_W'(1);
      end
      default: begin
      end
    endcase

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          id_q  <= stream_id_i;
          smp_q <= sample_i;
        end
      end
      ST_LOOKUP: begin
        drop_q   <= 1'b0;
        sig_ok_q <= 1'b0;
        sig_lo_q <= '0;
        sig_hi_q <= '0;
        iv_ok_q  <= 1'b0;
        iv_lo_q  <= '0;
        iv_hi_q  <= '0;
        if (id_oor) begin
          n_q    <= '0;
          mean_q <= '0;
          m2_q   <= '0;
          min_q  <= '0;
          max_q  <= '0;
        end else if (!seen_q[id_q]) begin
          n_q    <= CNT_W'(1);
          mean_q <= x_val;
          m2_q   <= '0;
          min_q  <= smp_q;
          max_q  <= smp_q;
        end else begin
          n_q    <= cnt_mem[id_q];
          mean_q <= mean_mem[id_q];
          m2_q   <= m2_mem[id_q];
          if (cnt_full) begin
            // The count cannot grow: drop the sample, report the entry.
            drop_q <= 1'b1;
            min_q  <= min_mem[id_q];
            max_q  <= max_mem[id_q];
          end else begin
            min_q  <= (smp_q < min_mem[id_q]) ? smp_q : min_mem[id_q];
            max_q  <= (smp_q > max_mem[id_q]) ? smp_q : max_mem[id_q];
          end
        end
      end
      ST_DIFF: begin
        // d = |x - mean|, then d / (n + 1) with d left-aligned.
        x_ge_q <= x_ge;
        d_q    <= sum[MEAN_W-1:0];
        mq_q   <= {sum[MEAN_W-1:0], {(UNIT_W-MEAN_W){1'b0}}};
        opa_q  <= UNIT_W'(n_q + CNT_W'(1));
        n_q    <= n_q + CNT_W'(1);
        acc_q  <= '0;
        cnt_q  <= STEP_W'(MEAN_W);
      end
      ST_MEAN_UPD: mean_q <= sum[MEAN_W-1:0];
      ST_DIFF2: begin
        // d * |x - new mean|
        opa_q <= UNIT_W'(d_q);
        mq_q  <= UNIT_W'(sum[MEAN_W-1:0]);
        acc_q <= '0;
        cnt_q <= STEP_W'(MEAN_W);
      end
      ST_M2_ADD: m2_q <= m2_nx;
      ST_SIG_PREP: begin
        mq_q  <= {sum[M2_W+SIG_K_W-1:0], {(UNIT_W-M2_W-SIG_K_W){1'b0}}};
        opa_q <= UNIT_W'(n_q - CNT_W'(1));
        acc_q <= '0;
        cnt_q <= STEP_W'(SIG_NUM_W);
      end
      ST_SIG_DIV, ST_MG_DIV: begin
        if (last_step) begin
          acc_q <= '0;
          opa_q <= '0;
          cnt_q <= STEP_W'(UNIT_W/2);
        end
      end
      ST_SIG_HI: sig_hi_q <= sat_hi(sum);
      ST_SIG_LO: begin
        sig_lo_q <= sat_lo(sum);
        sig_ok_q <= 1'b1;
      end
      ST_MG_PREP: begin
        opa_q <= UNIT_W'(m2_q);
        mq_q  <= UNIT_W'(MG_NUM);
        acc_q <= '0;
        cnt_q <= STEP_W'(MG_NUM_W);
      end
      ST_MG_MUL_A: begin
        if (last_step) begin
          hold_q <= mul_acc_nx << FRAC_BITS;
          opa_q  <= UNIT_W'(n_q);
          mq_q   <= UNIT_W'(n_q - CNT_W'(1));
          acc_q  <= '0;
          cnt_q  <= STEP_W'(CNT_W);
        end
      end
      ST_MG_MUL_N: begin
        if (last_step) begin
          opa_q <= mul_acc_nx;
          mq_q  <= UNIT_W'(MG_DEN);
          acc_q <= '0;
          cnt_q <= STEP_W'(MG_DEN_W);
        end
      end
      ST_MG_MUL_K: begin
        // One division by 10000 * n * (n - 1) equals the two nested ones.
        if (last_step) begin
          opa_q <= mul_acc_nx;
          mq_q  <= hold_q;
          acc_q <= '0;
          cnt_q <= STEP_W'(UNIT_W);
        end
      end
      ST_MG_HI: iv_hi_q <= sat_hi(sum);
      ST_MG_LO: begin
        iv_lo_q <= sat_lo(sum);
        iv_ok_q <= 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          o_id_q     <= id_q;
          o_n_q      <= n_q;
          o_mean_q   <= mean_q;
          o_min_q    <= min_q;
          o_max_q    <= max_q;
          o_sig_ok_q <= sig_ok_q;
          o_sig_lo_q <= sig_lo_q;
          o_sig_hi_q <= sig_hi_q;
          o_iv_ok_q  <= iv_ok_q;
          o_iv_lo_q  <= iv_lo_q;
          o_iv_hi_q  <= iv_hi_q;
          o_sat_q    <= drop_q || (m2_q == {M2_W{1'b1}});
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign stream_echo_o   = o_id_q;
  assign sample_count_o  = o_n_q;
  assign mean_value_o    = o_mean_q;
  assign min_seen_o      = o_min_q;
  assign max_seen_o      = o_max_q;
  assign sigma_ok_o      = o_sig_ok_q;
  assign sigma_low_o     = o_sig_lo_q;
  assign sigma_high_o    = o_sig_hi_q;
  assign interval_ok_o   = o_iv_ok_q;
  assign interval_low_o  = o_iv_lo_q;
  assign interval_high_o = o_iv_hi_q;
  assign saturated_o     = o_sat_q;

  // An accepted word always starts with the store lookup.
  a_accept_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_LOOKUP))
    else $error("accepted word did not start a lookup");

  // Iterative phases never run with an exhausted step counter.
  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode == U_MUL || mode == U_DIV || mode == U_SQRT) |-> (cnt_q != '0))
    else $error("shared unit stepped with zero count");

  // M2 never decreases across an update.
  a_m2_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M2_ADD) |=> (m2_q >= $past(m2_q)))
    else $error("M2 decreased");

  // A stream in range is marked seen after its lookup.
  a_seen_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP && !id_oor) |=> seen_q[id_q])
    else $error("stream not marked seen");

  // Sigma bounds are ordered whenever they are valid.
  a_sigma_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && sig_ok_q) |-> ($signed(sig_lo_q) <= $signed(sig_hi_q)))
    else $error("sigma bounds out of order");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for running_mean_variance_stats
// Drives sample words on several streams through the valid/ready input and
// checks every result word against a Welford predictor kept in the bench or,
// for hand-typed rows, the row. A short table of directed words runs first,
// then random words in three idling phases, with one long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import rmvs_pkg::*;

  // One result word, field by field.
  typedef struct packed {
    logic [ID_W-1:0]         echo;
    logic [CNT_W-1:0]        count;
    logic [MEAN_W-1:0]       mean;
    logic [SMP_W-1:0]        min_v;
    logic [SMP_W-1:0]        max_v;
    logic                    sig_ok;
    logic [BND_W-1:0]        sig_lo;
    logic [BND_W-1:0]        sig_hi;
    logic                    iv_ok;
    logic [BND_W-1:0]        iv_lo;
    logic [BND_W-1:0]        iv_hi;
    logic                    sat;
  } stats_word_t;

  // A directed row. When hand_typed is set, the expected count, mean, min
  // and max come from the row itself and every bound field must be zero.
  typedef struct packed {
    logic              hand_typed;
    logic [ID_W-1:0]   id;
    logic [SMP_W-1:0]  smp;
    logic [CNT_W-1:0]  cnt;
    logic [MEAN_W-1:0] mean;
    logic [SMP_W-1:0]  mn;
    logic [SMP_W-1:0]  mx;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  localparam logic [SMP_W-1:0] SMP_MAX = {SMP_W{1'b1}};
  localparam logic [BND_W-1:0] BND_POS_MAX = {1'b0, {(BND_W-1){1'b1}}};
  localparam logic [63:0] BND_NEG_MAG = 64'h800_0000_0000;
  localparam logic [63:0] M2_FULL = {64{1'b1}};
  localparam logic [CNT_W-1:0] CNT_FULL = {CNT_W{1'b1}};

  // The table opens each of several streams with an extreme or a plain
  // first sample, then grows a normal stream, then drives one stream back
  // and forth between zero and full scale until its M2 saturates.
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{1'b1, 4'd0,  24'd0,      32'd1, 40'd0,            24'd0,      24'd0},
    '{1'b1, 4'd1,  24'hFFFFFF, 32'd1, 40'hFFFFFF_0000,  24'hFFFFFF, 24'hFFFFFF},
    '{1'b1, 4'd15, 24'd1,      32'd1, 40'h1_0000,       24'd1,      24'd1},
    '{1'b1, 4'd2,  24'h5A5A5A, 32'd1, 40'h5A5A5A_0000,  24'h5A5A5A, 24'h5A5A5A},
    '{1'b0, 4'd2,  24'hA5A5A5, 32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd2,  24'h800000, 32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd0,  24'd0,      32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd15, 24'd3,      32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'd0,      32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'hFFFFFF, 32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'd0,      32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'hFFFFFF, 32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'd0,      32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'hFFFFFF, 32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'd0,      32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'hFFFFFF, 32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'd0,      32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'hFFFFFF, 32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b0, 4'd1,  24'h123456, 32'd0, 40'd0, 24'd0, 24'd0},
    '{1'b1, 4'd7,  24'hFFFFFF, 32'd1, 40'hFFFFFF_0000,  24'hFFFFFF, 24'hFFFFFF}
  };

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [ID_W-1:0] stream_id_i;
  logic [SMP_W-1:0] sample_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [ID_W-1:0] stream_echo_o;
  logic [CNT_W-1:0] sample_count_o;
  logic [MEAN_W-1:0] mean_value_o;
  logic [SMP_W-1:0] min_seen_o;
  logic [SMP_W-1:0] max_seen_o;
  logic sigma_ok_o;
  logic signed [BND_W-1:0] sigma_low_o;
  logic signed [BND_W-1:0] sigma_high_o;
  logic interval_ok_o;
  logic signed [BND_W-1:0] interval_low_o;
  logic signed [BND_W-1:0] interval_high_o;
  logic saturated_o;

  running_mean_variance_stats u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .stream_id_i     (stream_id_i),
    .sample_i        (sample_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .stream_echo_o   (stream_echo_o),
    .sample_count_o  (sample_count_o),
    .mean_value_o    (mean_value_o),
    .min_seen_o      (min_seen_o),
    .max_seen_o      (max_seen_o),
    .sigma_ok_o      (sigma_ok_o),
    .sigma_low_o     (sigma_low_o),
    .sigma_high_o    (sigma_high_o),
    .interval_ok_o   (interval_ok_o),
    .interval_low_o  (interval_low_o),
    .interval_high_o (interval_high_o),
    .saturated_o     (saturated_o)
  );

  // Predictor state: one entry per stream, mirroring the block's stores.
  logic        seen_q   [NUM_STREAMS];
  logic [63:0] count_q  [NUM_STREAMS];
  logic [63:0] mean_q   [NUM_STREAMS];
  logic [63:0] sqdev_q  [NUM_STREAMS];
  logic [63:0] min_q    [NUM_STREAMS];
  logic [63:0] max_q    [NUM_STREAMS];

  // Expected result words, oldest first.
  stats_word_t pending_stats[$];

  int mismatches = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int rcv_hold_cycles = 0;
  logic [SMP_W-1:0] stream_base [NUM_STREAMS];

  // Integer square root of a 128-bit value, rounded down, bit by bit.
  function automatic logic [63:0] floor_root(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    logic [127:0] cw;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      cw = {64'd0, c};
      if (cw * cw <= v) r = c;
    end
    return r;
  endfunction

  // floor(sqrt(floor(floor(m2 * k * 2^F / d1) / d2))): the spread term of a bound.
  function automatic logic [63:0] spread_root(input logic [63:0] m2, input logic [63:0] k,
                                               input logic [63:0] d1, input logic [63:0] d2);
    logic [127:0] a;
    a = ({64'd0, m2} * {64'd0, k}) << FRAC_BITS;
    a = a / {64'd0, d1};
    a = a / {64'd0, d2};
    return floor_root(a);
  endfunction

  function automatic logic [BND_W-1:0] bound_above(input logic [63:0] mu, input logic [63:0] s);
    logic [63:0] v;
    v = mu + s;
    return (v > {20'd0, BND_POS_MAX}) ? BND_POS_MAX : v[BND_W-1:0];
  endfunction

  // Lower bound may go negative; it is clamped to the signed 44-bit range.
  function automatic logic [BND_W-1:0] bound_below(input logic [63:0] mu, input logic [63:0] s);
    logic [63:0] v;
    logic [63:0] neg;
    if (mu >= s) begin
      v = mu - s;
      return (v > {20'd0, BND_POS_MAX}) ? BND_POS_MAX : v[BND_W-1:0];
    end
    neg = s - mu;
    if (neg > BND_NEG_MAG) neg = BND_NEG_MAG;
    v = 64'd0 - neg;
    return v[BND_W-1:0];
  endfunction

  // Applies one sample to the predictor state and returns the result word.
  function automatic stats_word_t welford_update(input logic [ID_W-1:0] id,
                                                 input logic [SMP_W-1:0] smp);
    stats_word_t r;
    logic [63:0] x;
    logic [63:0] mu;
    logic [63:0] d;
    logic [63:0] d2;
    logic [63:0] n;
    logic [63:0] s;
    logic [127:0] p;
    logic dropped;
    r = '{default: '0};
    r.echo = id;
    dropped = 1'b0;
    if (int'(id) >= NUM_STREAMS) return r;
    x = {24'd0, smp, 16'd0};
    if (!seen_q[id]) begin
      seen_q[id]  = 1'b1;
      count_q[id] = 64'd1;
      mean_q[id]  = x;
      sqdev_q[id] = '0;
      min_q[id]   = {40'd0, smp};
      max_q[id]   = {40'd0, smp};
    end else if (count_q[id] >= {32'd0, CNT_FULL}) begin
      dropped = 1'b1;
    end else begin
      n = count_q[id] + 64'd1;
      mu = mean_q[id];
      // The mean moves toward the sample by the truncated step.
      if (x >= mu) begin
        d = x - mu;
        mu = mu + d / n;
        d2 = x - mu;
      end else begin
        d = mu - x;
        mu = mu - d / n;
        d2 = mu - x;
      end
      p = ({64'd0, d} * {64'd0, d2}) >> FRAC_BITS;
      if (p[127:64] != '0 || sqdev_q[id] > M2_FULL - p[63:0]) sqdev_q[id] = M2_FULL;
      else sqdev_q[id] = sqdev_q[id] + p[63:0];
      count_q[id] = n;
      mean_q[id] = mu;
      if ({40'd0, smp} < min_q[id]) min_q[id] = {40'd0, smp};
      if ({40'd0, smp} > max_q[id]) max_q[id] = {40'd0, smp};
    end
    n = count_q[id];
    r.count = n[CNT_W-1:0];
    r.mean  = mean_q[id][MEAN_W-1:0];
    r.min_v = min_q[id][SMP_W-1:0];
    r.max_v = max_q[id][SMP_W-1:0];
    if (n >= 64'd2) begin
      s = spread_root(sqdev_q[id], 64'd9, n - 64'd1, 64'd1);
      r.sig_ok = 1'b1;
      r.sig_lo = bound_below(mean_q[id], s);
      r.sig_hi = bound_above(mean_q[id], s);
    end
    if (n > 64'd30) begin
      s = spread_root(sqdev_q[id], 64'd38416, 64'd10000, (n - 64'd1) * n);
      r.iv_ok = 1'b1;
      r.iv_lo = bound_below(mean_q[id], s);
      r.iv_hi = bound_above(mean_q[id], s);
    end
    r.sat = dropped || (sqdev_q[id] == M2_FULL);
    return r;
  endfunction

  // Offers one word, idling first at the current rate, and records the
  // expected result once the handshake completes. Valid is only lowered
  // during an idle cycle, so back-to-back words never toggle it.
  task automatic offer_word(input logic [ID_W-1:0] id, input logic [SMP_W-1:0] smp,
                            input logic hand_typed, input stats_word_t typed_exp);
    stats_word_t e;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    stream_id_i <= id;
    sample_i    <= smp;
    do @(posedge clk_i); while (!in_ready_o);
    e = welford_update(id, smp);
    pending_stats = {pending_stats, (hand_typed ? typed_exp : e)};
  endtask

  // Random word: half of the traffic is drawn from four streams so that their
  // counts climb well past the interval threshold. Samples cluster around a
  // per-stream base most of the time, with full-range noise and extremes.
  task automatic offer_random;
    logic [ID_W-1:0] id;
    logic [SMP_W-1:0] smp;
    int pick;
    stats_word_t none;
    none = '{default: '0};
    id = ($urandom_range(1) == 0) ? ID_W'($urandom_range(3)) : ID_W'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 55)      smp = stream_base[id] + SMP_W'($urandom_range(4095));
    else if (pick < 80) smp = SMP_W'($urandom);
    else if (pick < 90) smp = SMP_W'($urandom_range(255));
    else if (pick < 95) smp = SMP_MAX;
    else                smp = '0;
    offer_word(id, smp, 1'b0, none);
  endtask

  // The sender stops offering while it waits, so no word is taken twice.
  task automatic drain_results;
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Generous time limit for the whole run.
  initial begin
    #40_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Result side: checks each accepted word, then picks the next ready level.
  // A long hold counts down here, one cycle per edge.
  initial begin
    stats_word_t e;
    stats_word_t got;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = '{stream_echo_o, sample_count_o, mean_value_o, min_seen_o, max_seen_o,
                sigma_ok_o, sigma_low_o, sigma_high_o, interval_ok_o, interval_low_o,
                interval_high_o, saturated_o};
        if (pending_stats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word for stream %0d", got.echo);
        end else begin
          e = pending_stats.pop_front();
          if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected id %0d n %0d mean %h min %h max %h sig %b %h %h",
                       e.echo, e.count, e.mean, e.min_v, e.max_v, e.sig_ok, e.sig_lo, e.sig_hi);
              $display("          iv %b %h %h sat %b", e.iv_ok, e.iv_lo, e.iv_hi, e.sat);
              $display("  actual: id %0d n %0d mean %h min %h max %h sig %b %h %h",
                       got.echo, got.count, got.mean, got.min_v, got.max_v, got.sig_ok,
                       got.sig_lo, got.sig_hi);
              $display("          iv %b %h %h sat %b", got.iv_ok, got.iv_lo, got.iv_hi,
                       got.sat);
            end
          end
        end
      end
      if (rcv_hold_cycles > 0) begin
        rcv_hold_cycles--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Main sequence.
  initial begin
    stats_word_t t;
    dir_row_t row;
    in_valid_i  = 1'b0;
    stream_id_i = '0;
    sample_i    = '0;
    rst_ni      = 1'b0;
    for (int i = 0; i < NUM_STREAMS; i++) begin
      seen_q[i] = 1'b0;
      count_q[i] = '0;
      mean_q[i] = '0;
      sqdev_q[i] = '0;
      min_q[i] = '0;
      max_q[i] = '0;
      stream_base[i] = SMP_W'($urandom);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: sender idles 27 percent, receiver 65 percent.
    snd_idle_pct = 27;
    rcv_idle_pct = 65;

    // Directed table. Hand-typed rows are first samples, so every bound
    // field and the saturation flag must read zero.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      t = '{default: '0};
      t.echo  = row.id;
      t.count = row.cnt;
      t.mean  = row.mean;
      t.min_v = row.mn;
      t.max_v = row.mx;
      offer_word(row.id, row.smp, row.hand_typed, t);
    end

    // Long output stall while the sender keeps offering words, so that the
    // output register and the sequencer both fill and the input stalls.
    drain_results();
    rcv_hold_cycles = 3000;
    snd_idle_pct = 0;
    repeat (8) offer_random();
    snd_idle_pct = 27;

    for (int i = 0; i < 440; i++) offer_random();

    // Sender pauses here until every expected word has come back.
    drain_results();

    // Phase two: the idling rates swap.
    snd_idle_pct = 65;
    rcv_idle_pct = 27;
    for (int i = 0; i < 470; i++) offer_random();

    // Phase three: neither side idles.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    for (int i = 0; i < 470; i++) offer_random();
    @(posedge clk_i);
    in_valid_i <= 1'b0;

    drain_results();
    repeat (500) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rmvs_pkg.sv
rtl/running_mean_variance_stats.sv
bench/testbench.sv
